/* hw/rtl/bft_pkg.sv */
// Shared definitions for the byte frame transceiver: field widths, phase codes,
// result status codes and configuration register indexes.
// No dependencies.
package bft_pkg;

	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 16;
	localparam int STATUS_W = 3;
	localparam int PHASE_W  = 3;
	localparam int MAX_RES  = 5;
	localparam int CNT_W    = 3;
	localparam int ADDR_W   = 4;
	localparam int PDATA_W  = 32;
	localparam int TDATA_W  = 40;
	localparam int TUSER_W  = 4;

	localparam logic [PHASE_W-1:0] PH_ID      = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SIZE_HI = 3'd1;
	localparam logic [PHASE_W-1:0] PH_SIZE_LO = 3'd2;
	localparam logic [PHASE_W-1:0] PH_DATA    = 3'd3;
	localparam logic [PHASE_W-1:0] PH_SUM     = 3'd4;

	localparam logic [STATUS_W-1:0] ST_TX       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_HDR_OK   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ID_BAD   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_PAYLOAD  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FRAME_OK = 3'd4;
	localparam logic [STATUS_W-1:0] ST_SUM_BAD  = 3'd5;

	localparam logic [1:0] REG_NODE_ID      = 2'd0;
	localparam logic [1:0] REG_FRAME_LENGTH = 2'd1;
	localparam logic [1:0] REG_DIRECTION    = 2'd2;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

/* hw/rtl/byte_frame_transceiver.sv */
// Half-duplex byte framer and deframer with an APB register port.
// Depends on bft_pkg.
//
// Each accepted input byte is processed in the cycle it is accepted and its
// results are loaded into a result buffer of up to five words, which drains
// one word per cycle on the master side while m_tready is high. A new byte is
// taken whenever the buffer is empty or is handing over its final word, so a
// byte that yields at most one result sustains one byte per cycle while
// m_tready is high; a byte that yields more (first transmit byte with header,
// last one with checksum, up to five) holds the slave side until its burst is
// on its final word. Writing the direction register re-arms the frame state.
module byte_frame_transceiver (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bft_pkg::ADDR_W-1:0]      paddr,
	input  logic [bft_pkg::PDATA_W-1:0]     pwdata,
	output logic [bft_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata: in_byte[7:0]
	input  logic [bft_pkg::BYTE_W-1:0]      s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata: out_byte[7:0], byte_index[23:8], received_length[39:24]
	output logic [bft_pkg::TDATA_W-1:0]     m_tdata,
	// m_tuser: status[2:0], frame_end[3]
	output logic [bft_pkg::TUSER_W-1:0]     m_tuser,
	output logic                            m_tlast
);
	import bft_pkg::*;

	byte_t              node_id_q;
	logic [LEN_W-1:0]   frame_length_q;
	logic               direction_q;

	logic [PHASE_W-1:0] phase_q;
	logic [LEN_W-1:0]   bc_q;
	byte_t              sum_q;
	logic [LEN_W-1:0]   ls_q;

	byte_t              bytes_q [MAX_RES];
	logic [CNT_W-1:0]   rem_q;
	logic [STATUS_W-1:0] st_q;
	logic [LEN_W-1:0]   idx_q;
	logic [LEN_W-1:0]   rlen_q;
	logic               fend_q;

	logic [PHASE_W-1:0] ph_n;
	logic [LEN_W-1:0]   bc_n;
	byte_t              sum_n;
	logic [LEN_W-1:0]   ls_n;
	byte_t              bytes_n [MAX_RES];
	logic [CNT_W-1:0]   cnt_n;
	logic [STATUS_W-1:0] st_n;
	logic [LEN_W-1:0]   idx_n;
	logic [LEN_W-1:0]   rlen_n;
	logic               fend_n;

	logic               cfg_wr;
	logic [1:0]         reg_idx;
	logic               in_acc;
	logic               out_acc;
	byte_t              b;
	logic [LEN_W-1:0]   base_bc;
	byte_t              base_sum;
	byte_t              sum_tx;
	byte_t              sum_rx;
	logic               last_tx;
	logic               last_rx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_NODE_ID:      prdata = {{(PDATA_W-BYTE_W){1'b0}}, node_id_q};
			REG_FRAME_LENGTH: prdata = {{(PDATA_W-LEN_W){1'b0}}, frame_length_q};
			REG_DIRECTION:    prdata = {{(PDATA_W-1){1'b0}}, direction_q};
			default:          prdata = '0;
		endcase
	end

	assign m_tvalid = (rem_q != '0);
	assign m_tlast  = (rem_q == CNT_W'(1));
	assign out_acc  = m_tvalid && m_tready;
	assign s_tready = !m_tvalid || (out_acc && m_tlast);
	assign in_acc   = s_tvalid && s_tready;

	assign m_tdata = {rlen_q, idx_q, bytes_q[0]};
	assign m_tuser = {fend_q && m_tlast, st_q};

	assign b        = s_tdata;
	assign base_bc  = (phase_q == PH_DATA) ? bc_q : '0;
	assign base_sum = (phase_q == PH_DATA) ? sum_q : '0;
	assign sum_tx   = base_sum + b;
	assign sum_rx   = sum_q + b;
	assign last_tx  = ({1'b0, base_bc} + 17'd1) >= {1'b0, frame_length_q};
	assign last_rx  = ({1'b0, bc_q} + 17'd1) >= {1'b0, frame_length_q};

	always_comb begin
		ph_n   = phase_q;
		bc_n   = bc_q;
		sum_n  = sum_q;
		ls_n   = ls_q;
		cnt_n  = '0;
		st_n   = ST_TX;
		idx_n  = '0;
		rlen_n = '0;
		fend_n = 1'b0;
		for (int i = 0; i < MAX_RES; i++) begin
			bytes_n[i] = b;
		end
		if (!direction_q) begin
			if (phase_q != PH_DATA) begin
				bytes_n[0] = node_id_q;
				bytes_n[1] = frame_length_q[15:8];
				bytes_n[2] = frame_length_q[7:0];
				bytes_n[3] = b;
				bytes_n[4] = sum_tx;
				cnt_n      = last_tx ? CNT_W'(5) : CNT_W'(4);
			end else begin
				bytes_n[0] = b;
				bytes_n[1] = sum_tx;
				cnt_n      = last_tx ? CNT_W'(2) : CNT_W'(1);
			end
			if (last_tx) begin
				ph_n   = PH_ID;
				bc_n   = '0;
				sum_n  = '0;
				fend_n = 1'b1;
			end else begin
				ph_n  = PH_DATA;
				bc_n  = base_bc + LEN_W'(1);
				sum_n = sum_tx;
			end
		end else begin
			rlen_n = ls_q;
			unique case (phase_q)
				PH_SIZE_HI: begin
					ls_n = {b, 8'h00};
					ph_n = PH_SIZE_LO;
				end
				PH_SIZE_LO: begin
					ls_n   = {ls_q[15:8], b};
					rlen_n = {ls_q[15:8], b};
					ph_n   = PH_DATA;
					bc_n   = '0;
					sum_n  = '0;
					cnt_n  = CNT_W'(1);
					st_n   = ST_HDR_OK;
				end
				PH_DATA: begin
					sum_n = sum_rx;
					cnt_n = CNT_W'(1);
					st_n  = ST_PAYLOAD;
					idx_n = bc_q;
					if (last_rx) begin
						ph_n = PH_SUM;
					end else begin
						bc_n = bc_q + LEN_W'(1);
					end
				end
				PH_SUM: begin
					bytes_n[0] = sum_q;
					cnt_n      = CNT_W'(1);
					st_n       = (sum_q == b) ? ST_FRAME_OK : ST_SUM_BAD;
					fend_n     = 1'b1;
					ph_n       = PH_ID;
					bc_n       = '0;
					sum_n      = '0;
				end
				default: begin
					if (b == node_id_q) begin
						ph_n = PH_SIZE_HI;
					end else begin
						ph_n  = PH_ID;
						cnt_n = CNT_W'(1);
						st_n  = ST_ID_BAD;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q      <= '0;
			frame_length_q <= LEN_W'(1);
			direction_q    <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_NODE_ID:      node_id_q <= pwdata[BYTE_W-1:0];
				REG_FRAME_LENGTH: frame_length_q <= pwdata[LEN_W-1:0];
				REG_DIRECTION:    direction_q <= pwdata[0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ID;
			bc_q    <= '0;
			sum_q   <= '0;
			ls_q    <= '0;
		end else if (cfg_wr && (reg_idx == REG_DIRECTION)) begin
			phase_q <= PH_ID;
			bc_q    <= '0;
			sum_q   <= '0;
		end else if (in_acc) begin
			phase_q <= ph_n;
			bc_q    <= bc_n;
			sum_q   <= sum_n;
			ls_q    <= ls_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (in_acc) begin
			rem_q <= cnt_n;
		end else if (out_acc) begin
			rem_q <= rem_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			bytes_q <= bytes_n;
			st_q    <= st_n;
			idx_q   <= idx_n;
			rlen_q  <= rlen_n;
			fend_q  <= fend_n;
		end else if (out_acc) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				bytes_q[i] <= bytes_q[i+1];
			end
		end
	end

`ifndef SYNTHESIS
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= CNT_W'(MAX_RES))
		else $error("result buffer count out of range");

	a_fend_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3] |-> m_tlast)
		else $error("frame end on a word that is not the last of its burst");

	a_tx_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!direction_q |-> (phase_q == PH_ID) || (phase_q == PH_DATA))
		else $error("transmit mode left in a receive phase");

	a_tx_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st_q == ST_TX) |-> (idx_q == '0) && (rlen_q == '0))
		else $error("transmit word carries index or length");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while a result burst is stalled");
`endif

endmodule
